// ===== sv/jct_pkg.sv =====
// Shared types, constants and the axis quantizer for the joystick cursor tracker.
package jct_pkg;

    localparam int TimeW   = 64;
    localparam int AdcW    = 12;
    localparam int PosW    = 16;
    localparam int CfgW    = 32;
    localparam int CfgIdxW = 2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] RegUpdatePeriod   = 2'd0;
    localparam logic [CfgIdxW-1:0] RegVisibleTimeout = 2'd1;
    localparam logic [CfgIdxW-1:0] RegButtonLockout  = 2'd2;

    // Configuration reset values
    localparam logic [CfgW-1:0] UpdatePeriodRst   = 32'd30000;
    localparam logic [CfgW-1:0] VisibleTimeoutRst = 32'd5000000;
    localparam logic [CfgW-1:0] ButtonLockoutRst  = 32'd200000;

    // Quantizer thresholds
    localparam logic [AdcW-1:0] ThBigHi   = 12'd3072;
    localparam logic [AdcW-1:0] ThSmallHi = 12'd2560;
    localparam logic [AdcW-1:0] ThBigLo   = 12'd512;
    localparam logic [AdcW-1:0] ThSmallLo = 12'd1536;

    // Step sizes and home position
    localparam logic signed [PosW-1:0] StepBig   = 16'sd10;
    localparam logic signed [PosW-1:0] StepSmall = 16'sd3;
    localparam logic signed [PosW-1:0] PosRst    = 16'sd120;

    typedef struct packed {
        logic [TimeW-1:0] time_us;
        logic             button_level;
        logic [AdcW-1:0]  adc_x;
        logic [AdcW-1:0]  adc_y;
    } poll_t;

    typedef struct packed {
        logic                   updated;
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic                   visible;
    } result_t;

    typedef struct packed {
        logic [CfgW-1:0] update_period;
        logic [CfgW-1:0] visible_timeout;
        logic [CfgW-1:0] button_lockout;
    } cfg_t;

    // Map one ADC sample to a signed step of -10, -3, 0, +3 or +10
    function automatic logic signed [PosW-1:0] quantize(input logic [AdcW-1:0] a);
        logic signed [PosW-1:0] step;
        if (a > ThBigHi) begin
            step = StepBig;
        end else if (a > ThSmallHi) begin
            step = StepSmall;
        end else if (a < ThBigLo) begin
            step = -StepBig;
        end else if (a < ThSmallLo) begin
            step = -StepSmall;
        end else begin
            step = '0;
        end
        return step;
    endfunction

endpackage

// ===== sv/jct_tracker.sv =====
// Cursor state and the per-poll update: rate gate, steps, press lockout, visibility.
module jct_tracker (
    input  logic            aclk,
    input  logic            aresetn,
    input  jct_pkg::cfg_t   cfg,
    input  jct_pkg::poll_t  poll,
    input  logic            step_en,
    output jct_pkg::result_t result
);
    import jct_pkg::*;

    logic [TimeW-1:0]       last_poll_reg,  last_poll_next;
    logic                   prev_btn_reg,   prev_btn_next;
    logic [TimeW-1:0]       last_press_reg, last_press_next;
    logic [TimeW-1:0]       activity_reg,   activity_next;
    logic                   visible_reg,    visible_next;
    logic signed [PosW-1:0] cur_x_reg,      cur_x_next;
    logic signed [PosW-1:0] cur_y_reg,      cur_y_next;

    logic                   poll_ok;
    logic                   move;
    logic                   press;
    logic                   act;
    logic signed [PosW-1:0] dx;
    logic signed [PosW-1:0] dy;
    logic [TimeW-1:0]       act_time;
    logic                   vis_new;

    // Gate, quantize and press detection; all differences wrap modulo 2^64
    always_comb begin
        poll_ok  = (poll.time_us - last_poll_reg) >= {{(TimeW-CfgW){1'b0}}, cfg.update_period};
        dx       = quantize(poll.adc_x);
        dy       = quantize(poll.adc_y);
        move     = (dx != '0) || (dy != '0);
        press    = poll.button_level && !prev_btn_reg
                   && ((poll.time_us - last_press_reg)
                       > {{(TimeW-CfgW){1'b0}}, cfg.button_lockout});
        act      = move || press;
        act_time = act ? poll.time_us : activity_reg;
        // fresh activity means zero elapsed time, so only a zero timeout hides it
        vis_new  = act ? (cfg.visible_timeout != '0)
                       : ((poll.time_us - activity_reg)
                          < {{(TimeW-CfgW){1'b0}}, cfg.visible_timeout});
    end

    // Next state: only an accepted poll moves anything
    always_comb begin
        last_poll_next  = last_poll_reg;
        prev_btn_next   = prev_btn_reg;
        last_press_next = last_press_reg;
        activity_next   = activity_reg;
        visible_next    = visible_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        if (poll_ok) begin
            last_poll_next  = poll.time_us;
            prev_btn_next   = poll.button_level;
            last_press_next = press ? poll.time_us : last_press_reg;
            activity_next   = act_time;
            visible_next    = vis_new;
            cur_x_next      = cur_x_reg + dx;
            cur_y_next      = cur_y_reg + dy;
        end
    end

    // Result reflects the state after this poll
    always_comb begin
        result.updated = poll_ok && act;
        result.pos_x   = cur_x_next;
        result.pos_y   = cur_y_next;
        result.visible = visible_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_poll_reg  <= '0;
            prev_btn_reg   <= 1'b0;
            last_press_reg <= '0;
            activity_reg   <= '0;
            visible_reg    <= 1'b1;
            cur_x_reg      <= PosRst;
            cur_y_reg      <= PosRst;
        end else if (step_en) begin
            last_poll_reg  <= last_poll_next;
            prev_btn_reg   <= prev_btn_next;
            last_press_reg <= last_press_next;
            activity_reg   <= activity_next;
            visible_reg    <= visible_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
        end
    end

endmodule

// ===== sv/joystick_cursor_tracker_unit.sv =====
// Top level of the joystick cursor tracker: handshakes, config registers, result register.
//
// Usage:
//   Input channel (s_*): one poll per item, carrying a microsecond timestamp,
//   the button level and two 12-bit ADC samples. Output channel (m_*): one
//   result item per poll, with the updated flag, the 16-bit signed cursor
//   position and the visible flag after that poll.
//   Config port: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0 update period, 1 visible timeout, 2 button lockout); index 3 is
//   ignored. Write only while no item is in flight.
//   The result is registered: the input register feeds the result register.
//   Throughput: one item per cycle while m_ready is high; the state update
//   is a single pass of 64-bit subtract/compare logic between the input and
//   result registers. Reset: clears both pipeline stages, loads the register
//   defaults and puts the cursor at (120, 120), visible.
//   Stall: when m_ready is low the result holds; the input register still
//   takes one more item, after which s_ready drops until the result is taken.
module joystick_cursor_tracker_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [jct_pkg::TimeW-1:0]     s_time_us,
    input  logic                          s_button_level,
    input  logic [jct_pkg::AdcW-1:0]      s_adc_x,
    input  logic [jct_pkg::AdcW-1:0]      s_adc_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_updated,
    output logic signed [jct_pkg::PosW-1:0] m_pos_x,
    output logic signed [jct_pkg::PosW-1:0] m_pos_y,
    output logic                          m_visible,
    input  logic                          cfg_wr_en,
    input  logic [jct_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [jct_pkg::CfgW-1:0]      cfg_wdata
);
    import jct_pkg::*;

    cfg_t    cfg_reg;
    poll_t   poll_reg;
    logic    in_valid_reg;
    result_t result_reg;
    logic    out_valid_reg;
    result_t result_next;
    logic    advance;

    // Pipeline control: input stage moves when the result stage is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.update_period   <= UpdatePeriodRst;
            cfg_reg.visible_timeout <= VisibleTimeoutRst;
            cfg_reg.button_lockout  <= ButtonLockoutRst;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                RegUpdatePeriod:   cfg_reg.update_period   <= cfg_wdata;
                RegVisibleTimeout: cfg_reg.visible_timeout <= cfg_wdata;
                RegButtonLockout:  cfg_reg.button_lockout  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            poll_reg.time_us      <= s_time_us;
            poll_reg.button_level <= s_button_level;
            poll_reg.adc_x        <= s_adc_x;
            poll_reg.adc_y        <= s_adc_y;
        end
    end

    jct_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .poll    (poll_reg),
        .step_en (advance),
        .result  (result_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_updated = result_reg.updated;
    assign m_pos_x   = result_reg.pos_x;
    assign m_pos_y   = result_reg.pos_y;
    assign m_visible = result_reg.visible;

endmodule

// ===== sv/jct_checker.sv =====
// Port-level checks for the joystick cursor tracker, bound to the top level.
module jct_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_updated,
    input logic signed [jct_pkg::PosW-1:0] m_pos_x,
    input logic signed [jct_pkg::PosW-1:0] m_pos_y,
    input logic                            m_visible,
    input logic                            cfg_wr_en,
    input logic [jct_pkg::CfgIdxW-1:0]     cfg_index,
    input logic [jct_pkg::CfgW-1:0]        cfg_wdata
);
    import jct_pkg::*;

    logic [1:0]             inflight_reg;
    logic                   have_prev_reg;
    logic signed [PosW-1:0] prev_x_reg;
    logic signed [PosW-1:0] prev_y_reg;
    logic [CfgW-1:0]        timeout_reg;
    logic                   in_acc;
    logic                   out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // Items in flight and last delivered position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg  <= '0;
            have_prev_reg <= 1'b0;
            timeout_reg   <= VisibleTimeoutRst;
        end else begin
            inflight_reg <= inflight_reg + {1'b0, in_acc} - {1'b0, out_acc};
            if (out_acc) begin
                have_prev_reg <= 1'b1;
            end
            if (cfg_wr_en && cfg_index == RegVisibleTimeout) begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_acc) begin
            prev_x_reg <= m_pos_x;
            prev_y_reg <= m_pos_y;
        end
    end

    // No result without an item behind it
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 2'd0)
        else $error("result item with no item in flight");

    // At most two items held inside
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg != 2'd3)
        else $error("more than two items in flight");

    // A poll without update leaves the cursor where it was
    a_hold_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && !m_updated && have_prev_reg |->
            m_pos_x == prev_x_reg && m_pos_y == prev_y_reg)
        else $error("cursor moved on a poll without update");

    // Fresh activity makes the cursor visible unless the timeout is zero
    a_vis_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_updated |-> m_visible == (timeout_reg != '0))
        else $error("visibility wrong after activity");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x) && $stable(m_pos_y))
        else $error("stalled result item changed");

endmodule

bind joystick_cursor_tracker_unit jct_checker u_jct_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_updated (m_updated),
    .m_pos_x   (m_pos_x),
    .m_pos_y   (m_pos_y),
    .m_visible (m_visible),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
);
